>>> rtl/brr_pkg.sv
package brr_pkg;

	localparam int BITS    = 4096;
	localparam int WORD_W  = 64;
	localparam int WORDS   = BITS / WORD_W;
	localparam int WADDR_W = $clog2(WORDS);
	localparam int OFF_W   = $clog2(WORD_W);
	localparam int POS_W   = $clog2(BITS);
	localparam int SIZE_W  = POS_W + 1;

	localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(BITS);

	typedef enum logic [1:0] {
		REQ_TEST  = 2'd0,
		REQ_CLEAR = 2'd1,
		REQ_SET   = 2'd2,
		REQ_FIND  = 2'd3
	} req_t;

	// Control for the shared word unit: window [lo, hi] inclusive, scan direction
	// and the value written into the window.
	typedef struct packed {
		logic             scan_high;
		logic             set;
		logic [OFF_W-1:0] lo;
		logic [OFF_W-1:0] hi;
	} unit_ctl_t;

	typedef struct packed {
		logic             found;
		logic [OFF_W-1:0] idx;
	} unit_res_t;

endpackage

>>> rtl/brr_ram.sv
module brr_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/brr_word_unit.sv
module brr_word_unit (
	input  logic [brr_pkg::WORD_W-1:0] word,
	input  brr_pkg::unit_ctl_t         ctl,
	output brr_pkg::unit_res_t         res,
	output logic [brr_pkg::WORD_W-1:0] new_word
);

	import brr_pkg::*;

	logic [WORD_W-1:0] win;
	logic [WORD_W-1:0] cand;
	logic [WORD_W-1:0] scan;
	logic [WORD_W-1:0] iso;
	logic [OFF_W-1:0]  low_idx;

	// The window runs from bit lo up to bit hi; ~hi is the right shift 63 - hi.
	assign win  = ({WORD_W{1'b1}} << ctl.lo) & ({WORD_W{1'b1}} >> (~ctl.hi));
	assign cand = ~word & win;

	always_comb begin
		for (int k = 0; k < WORD_W; k++) begin
			scan[k] = ctl.scan_high ? cand[WORD_W-1-k] : cand[k];
		end
	end

	// Isolate the lowest set bit, then encode its position.
	assign iso = scan & (~scan + WORD_W'(1));

	always_comb begin
		low_idx = '0;
		for (int k = 0; k < WORD_W; k++) begin
			if (iso[k]) begin
				low_idx = low_idx | OFF_W'(k);
			end
		end
	end

	assign res.found = |cand;
	assign res.idx   = ctl.scan_high ? ~low_idx : low_idx;
	assign new_word  = ctl.set ? (word | win) : (word & ~win);

endmodule

>>> rtl/bitmap_range_run_engine.sv
// Channel  Direction  Handshake            Payload
// s        in         s_tvalid/s_tready    s_tuser: req_type; s_tdata: first_pos, end_pos
// m        out        m_tvalid/m_tready    m_tdata: bit_value, run_start, run_end
// cfg      in         cfg_valid/cfg_ready  cfg_data: bitmap_size
//
// One request is in flight at a time. A bit test reads its word in ST_START, takes the bit
// in ST_TEST and loads the result register in ST_OUT; a range update reads, updates and
// writes back each word it touches in ST_RANGE; a run search walks left in ST_LEFT, then
// right in ST_RIGHT, one word at a time via the single read port and one shared word unit.
// Reset clears a valid bit per word, so every word reads as zero with no clearing pass.
// A stalled result waits in the output register; the next request is taken meanwhile,
// and its own result waits in the last state until the register is free.
module bitmap_range_run_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [1:0]                    s_tuser,   // [1:0] req_type
	input  logic [31:0]                   s_tdata,   // [11:0] first_pos, [24:12] end_pos
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,   // [0] bit_value, [13:1] run_start,
	                                                 // [26:14] run_end
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [brr_pkg::SIZE_W-1:0]    cfg_data
);

	import brr_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_TEST,
		ST_RANGE,
		ST_LEFT,
		ST_RIGHT,
		ST_OUT
	} state_t;

	state_t              state_q;
	req_t                req_q;
	logic [POS_W-1:0]    pos_q;
	logic [SIZE_W-1:0]   stop_q;
	logic [SIZE_W-1:0]   lim_q;
	logic [SIZE_W-1:0]   size_q;
	logic [WADDR_W-1:0]  w_q;
	logic                bitv_q;
	logic [SIZE_W-1:0]   rs_q;
	logic [SIZE_W-1:0]   re_q;
	logic                m_tvalid_q;
	logic [31:0]         m_tdata_q;
	logic [WORDS-1:0]    valid_q;
	logic                rd_vld_s1;

	logic                rd_en;
	logic [WADDR_W-1:0]  rd_addr;
	logic                wr_en;
	logic [WORD_W-1:0]   rd_raw;
	logic [WORD_W-1:0]   word;
	logic [WORD_W-1:0]   new_word;
	unit_ctl_t           ctl;
	unit_res_t           res;

	logic [SIZE_W-1:0]   in_stop;
	logic [SIZE_W-1:0]   stop_m1;
	logic [WADDR_W-1:0]  w0;
	logic [OFF_W-1:0]    j0;
	logic [WADDR_W-1:0]  last_w;
	logic [OFF_W-1:0]    hi_off;
	logic [SIZE_W-1:0]   base;
	logic [SIZE_W-1:0]   hit_pos;
	logic [SIZE_W-1:0]   word_end;
	logic [SIZE_W-1:0]   pos_ext;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign in_stop  = s_tdata[24:12];
	assign pos_ext  = {1'b0, pos_q};
	assign stop_m1  = stop_q - SIZE_W'(1);
	assign w0       = pos_q[POS_W-1:OFF_W];
	assign j0       = pos_q[OFF_W-1:0];
	assign last_w   = stop_m1[POS_W-1:OFF_W];
	assign hi_off   = stop_m1[OFF_W-1:0];
	assign base     = {1'b0, w_q, {OFF_W{1'b0}}};
	assign hit_pos  = base + SIZE_W'(res.idx);
	assign word_end = base + SIZE_W'(WORD_W);

	// A word never written since reset reads as zero.
	assign word = rd_vld_s1 ? rd_raw : '0;

	brr_ram #(
		.WIDTH(WORD_W),
		.DEPTH(WORDS)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(w_q),
		.wr_data(new_word),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	brr_word_unit u_unit (
		.word    (word),
		.ctl     (ctl),
		.res     (res),
		.new_word(new_word)
	);

	always_comb begin
		rd_en         = 1'b0;
		rd_addr       = w0;
		wr_en         = 1'b0;
		ctl.scan_high = 1'b0;
		ctl.set       = 1'b0;
		ctl.lo        = '0;
		ctl.hi        = '1;
		case (state_q)
			ST_START: begin
				rd_en = 1'b1;
			end
			ST_RANGE: begin
				ctl.set = (req_q == REQ_SET);
				ctl.lo  = (w_q == w0) ? j0 : '0;
				ctl.hi  = (w_q == last_w) ? hi_off : '1;
				wr_en   = 1'b1;
				rd_en   = (w_q != last_w);
				rd_addr = w_q + WADDR_W'(1);
			end
			ST_LEFT: begin
				// The bit at the index is one, so including it in the window is harmless.
				ctl.scan_high = 1'b1;
				ctl.hi        = (w_q == w0) ? j0 : '1;
				rd_en         = 1'b1;
				rd_addr       = (res.found || w_q == '0) ? w0 : w_q - WADDR_W'(1);
			end
			ST_RIGHT: begin
				ctl.lo  = (w_q == w0) ? j0 : '0;
				rd_en   = !res.found && (word_end < lim_q);
				rd_addr = w_q + WADDR_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= SIZE_MAX;
			valid_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (cfg_valid) begin
				size_q <= cfg_data;
			end
			if (wr_en) begin
				valid_q[w_q] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_s1 <= valid_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			req_q      <= REQ_TEST;
			pos_q      <= '0;
			stop_q     <= '0;
			lim_q      <= '0;
			w_q        <= '0;
			bitv_q     <= 1'b0;
			rs_q       <= '0;
			re_q       <= '0;
		end else begin
			if (state_q == ST_OUT && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						req_q   <= req_t'(s_tuser);
						pos_q   <= s_tdata[POS_W-1:0];
						stop_q  <= (in_stop > SIZE_MAX) ? SIZE_MAX : in_stop;
						lim_q   <= (size_q > SIZE_MAX) ? SIZE_MAX : size_q;
						bitv_q  <= 1'b0;
						rs_q    <= '0;
						re_q    <= '0;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					w_q <= w0;
					case (req_q)
						REQ_TEST: begin
							state_q <= ST_TEST;
						end
						REQ_CLEAR, REQ_SET: begin
							state_q <= (pos_ext >= stop_q) ? ST_OUT : ST_RANGE;
						end
						REQ_FIND: begin
							if (pos_ext >= lim_q) begin
								rs_q    <= pos_ext;
								re_q    <= pos_ext;
								state_q <= ST_OUT;
							end else begin
								state_q <= ST_LEFT;
							end
						end
						default: begin
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_TEST: begin
					bitv_q  <= word[j0];
					state_q <= ST_OUT;
				end
				ST_RANGE: begin
					if (w_q == last_w) begin
						state_q <= ST_OUT;
					end else begin
						w_q <= w_q + WADDR_W'(1);
					end
				end
				ST_LEFT: begin
					if (w_q == w0 && !word[j0]) begin
						rs_q    <= pos_ext;
						re_q    <= pos_ext;
						state_q <= ST_OUT;
					end else if (res.found) begin
						rs_q    <= hit_pos + SIZE_W'(1);
						w_q     <= w0;
						state_q <= ST_RIGHT;
					end else if (w_q == '0) begin
						rs_q    <= '0;
						w_q     <= w0;
						state_q <= ST_RIGHT;
					end else begin
						w_q <= w_q - WADDR_W'(1);
					end
				end
				ST_RIGHT: begin
					// Bits at or beyond the size limit end the run.
					if (res.found) begin
						re_q    <= (hit_pos < lim_q) ? hit_pos : lim_q;
						state_q <= ST_OUT;
					end else if (word_end >= lim_q) begin
						re_q    <= lim_q;
						state_q <= ST_OUT;
					end else begin
						w_q <= w_q + WADDR_W'(1);
					end
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= {5'b0, re_q, rs_q, bitv_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> tb/tb_bitmap_range_run_engine.sv
module tb_bitmap_range_run_engine;
	import brr_pkg::*;

	typedef enum logic [1:0] {
		ENT_REQ,
		ENT_CFG,
		ENT_DRAIN
	} stim_kind_t;

	typedef struct {
		stim_kind_t        kind;
		req_t              op;
		logic [POS_W-1:0]  first_pos;
		logic [SIZE_W-1:0] end_pos;
		logic [SIZE_W-1:0] size;
	} stim_entry_t;

	typedef struct packed {
		logic              bit_value;
		logic [SIZE_W-1:0] run_start;
		logic [SIZE_W-1:0] run_end;
	} run_result_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [1:0]        s_tuser   = '0;   // [1:0] req_type
	logic [31:0]       s_tdata   = '0;   // [11:0] first_pos, [24:12] end_pos
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [31:0]       m_tdata;          // [0] bit_value, [13:1] run_start, [26:14] run_end
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [SIZE_W-1:0] cfg_data  = '0;

	bitmap_range_run_engine u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	// Shadow of the engine: bit i of the map is bitmap_shadow[i].
	logic [BITS-1:0]   bitmap_shadow = '0;
	logic [SIZE_W-1:0] size_shadow   = SIZE_MAX;

	stim_entry_t stim_q[$];
	run_result_t expected_runs[$];
	int          requests_sent = 0;
	int          results_seen  = 0;
	int          err_cnt       = 0;
	bit          tail_phase    = 1'b0;

	function automatic run_result_t apply_request(req_t op, logic [POS_W-1:0] pos,
			logic [SIZE_W-1:0] stop_in);
		run_result_t r;
		int          stop;
		int          lim;
		int          lo;
		int          hi;
		int          i;
		r = '0;
		case (op)
		REQ_TEST: begin
			r.bit_value = bitmap_shadow[pos];
		end
		REQ_CLEAR, REQ_SET: begin
			stop = (int'(stop_in) > BITS) ? BITS : int'(stop_in);
			for (i = int'(pos); i < stop; i++)
				bitmap_shadow[i] = (op == REQ_SET);
		end
		default: begin
			lim = (int'(size_shadow) > BITS) ? BITS : int'(size_shadow);
			lo  = int'(pos);
			hi  = int'(pos);
			if (lo < lim && bitmap_shadow[pos]) begin
				while (lo > 0 && bitmap_shadow[lo-1])
					lo--;
				hi = int'(pos) + 1;
				while (hi < lim && bitmap_shadow[hi])
					hi++;
			end
			r.run_start = SIZE_W'(lo);
			r.run_end   = SIZE_W'(hi);
		end
		endcase
		return r;
	endfunction

	function automatic void queue_req(req_t op, int pos, int stop);
		stim_entry_t e;
		e.kind      = ENT_REQ;
		e.op        = op;
		e.first_pos = POS_W'(pos);
		e.end_pos   = SIZE_W'(stop);
		e.size      = '0;
		stim_q.push_back(e);
	endfunction

	function automatic void queue_ctl(stim_kind_t kind, int size);
		stim_entry_t e;
		e.kind      = kind;
		e.op        = REQ_TEST;
		e.first_pos = '0;
		e.end_pos   = '0;
		e.size      = SIZE_W'(size);
		stim_q.push_back(e);
	endfunction

	// Request side. A new beat is offered only after the previous one was taken,
	// so tvalid never drops before its handshake.
	int s_gap    = 0;
	bit s_bursty = 1'b1;

	always @(posedge clk) begin
		stim_entry_t head;
		logic        nxt_valid;
		logic        nxt_cfg;
		bit          s_fire;
		int          in_flight;
		if (arst_n) begin
			s_fire    = s_tvalid && s_tready;
			nxt_valid = 1'b0;
			nxt_cfg   = 1'b0;
			if (s_fire) begin
				head = stim_q.pop_front();
				expected_runs.push_back(apply_request(head.op, head.first_pos, head.end_pos));
				requests_sent <= requests_sent + 1;
				if (s_bursty && !tail_phase && $urandom_range(0, 3) == 0)
					s_gap = $urandom_range(1, 17);
			end
			if (cfg_valid && cfg_ready) begin
				head = stim_q.pop_front();
				size_shadow = head.size;
			end
			// Results taken at this very edge are not counted yet, which only delays.
			in_flight = requests_sent + int'(s_fire) - results_seen;
			if ($urandom_range(0, 99) == 0)
				s_bursty = !s_bursty;
			if (s_gap > 0) begin
				s_gap--;
			end else if (stim_q.size() > 0) begin
				head = stim_q[0];
				case (head.kind)
				ENT_REQ: begin
					nxt_valid = 1'b1;
					s_tuser  <= head.op;
					s_tdata  <= {7'd0, head.end_pos, head.first_pos};
				end
				ENT_CFG: begin
					if (in_flight == 0) begin
						nxt_cfg   = 1'b1;
						cfg_data <= head.size;
					end
				end
				default: begin
					if (in_flight == 0)
						void'(stim_q.pop_front());
				end
				endcase
			end
			s_tvalid   <= nxt_valid;
			cfg_valid  <= nxt_cfg;
			tail_phase <= (stim_q.size() <= 60);
		end
	end

	// Result side.
	int r_stall  = 0;
	bit r_bursty = 1'b1;

	always @(posedge clk) begin
		run_result_t seen;
		run_result_t want;
		logic        nxt_ready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				seen = '{m_tdata[0], m_tdata[13:1], m_tdata[26:14]};
				if (results_seen >= requests_sent) begin
					$display({"%0t: expected no result, actual bit_value %0d",
						" run_start %0d run_end %0d"},
						$time, seen.bit_value, seen.run_start, seen.run_end);
					err_cnt++;
				end else begin
					want = expected_runs.pop_front();
					if (seen !== want) begin
						$display({"%0t: expected bit_value %0d run_start %0d run_end %0d,",
							" actual bit_value %0d run_start %0d run_end %0d"},
							$time, want.bit_value, want.run_start, want.run_end,
							seen.bit_value, seen.run_start, seen.run_end);
						err_cnt++;
					end
				end
				results_seen <= results_seen + 1;
			end
			if ($urandom_range(0, 99) == 0)
				r_bursty = !r_bursty;
			if (r_stall > 0) begin
				r_stall--;
				nxt_ready = 1'b0;
			end else if (r_bursty && !tail_phase && $urandom_range(0, 5) == 0) begin
				r_stall   = $urandom_range(0, 16);
				nxt_ready = 1'b0;
			end else begin
				nxt_ready = 1'b1;
			end
			m_tready <= nxt_ready;
		end
	end

	initial begin
		int   pos;
		int   stop;
		int   sel;
		int   size;
		int   hot_lo;
		int   hot_hi;
		req_t op;

		// Empty map, then a full map carved up at word edges and inside words.
		queue_req(REQ_TEST, 0, 0);
		queue_req(REQ_TEST, 4095, 8191);
		queue_req(REQ_FIND, 0, 0);
		queue_req(REQ_SET, 0, 4096);
		queue_req(REQ_FIND, 2047, 0);
		queue_req(REQ_CLEAR, 64, 128);
		queue_req(REQ_FIND, 10, 0);
		queue_req(REQ_FIND, 100, 0);
		queue_req(REQ_FIND, 128, 0);
		queue_req(REQ_CLEAR, 300, 200);
		queue_req(REQ_CLEAR, 500, 500);
		queue_req(REQ_CLEAR, 4000, 8191);
		queue_req(REQ_TEST, 4095, 0);
		queue_req(REQ_SET, 70, 75);
		queue_req(REQ_FIND, 72, 0);
		queue_req(REQ_CLEAR, 200, 256);
		queue_req(REQ_SET, 4090, 4096);
		queue_req(REQ_FIND, 4095, 0);
		queue_req(REQ_TEST, 4000, 0);
		// Searches clipped by a one-bit, an empty and an oversized bitmap.
		queue_ctl(ENT_CFG, 1);
		queue_req(REQ_FIND, 0, 0);
		queue_req(REQ_FIND, 1, 0);
		queue_ctl(ENT_CFG, 0);
		queue_req(REQ_FIND, 0, 0);
		queue_ctl(ENT_CFG, 8191);
		queue_req(REQ_FIND, 3000, 0);

		hot_lo = 256;
		hot_hi = 3999;
		for (int p = 0; p < 6; p++) begin
			case (p)
			0:       size = 4096;
			1:       size = $urandom_range(1, 4095);
			2:       size = $urandom_range(4097, 8191);
			3:       size = $urandom_range(64, 700);
			4:       size = $urandom_range(2000, 4095);
			default: size = 4096;
			endcase
			queue_ctl(ENT_CFG, size);
			for (int n = 0; n < 76; n++) begin
				if (n == 38 && (p == 1 || p == 4))
					queue_ctl(ENT_DRAIN, 0);
				case ($urandom_range(0, 3))
				0:       pos = $urandom_range(0, 4095);
				1:       pos = ($urandom_range(0, 63) * 64 + $urandom_range(0, 2) + 4095) % 4096;
				default: pos = hot_lo + $urandom_range(0, hot_hi - hot_lo);
				endcase
				sel = $urandom_range(0, 99);
				if (sel < 22) begin
					queue_req(REQ_TEST, pos, $urandom_range(0, 8191));
				end else if (sel < 62) begin
					case ($urandom_range(0, 19))
					0, 1, 2, 3, 4:       stop = pos + $urandom_range(0, 3);
					5, 6, 7, 8, 9, 10, 11: stop = pos + $urandom_range(1, 130);
					12, 13, 14, 15, 16:  stop = pos + $urandom_range(100, 900);
					17, 18:              stop = $urandom_range(0, pos);
					default:             stop = $urandom_range(0, 8191);
					endcase
					op = ($urandom_range(0, 99) < 55) ? REQ_SET : REQ_CLEAR;
					if (op == REQ_SET && stop > pos) begin
						hot_lo = pos;
						hot_hi = (stop > 4096) ? 4095 : stop - 1;
					end
					queue_req(op, pos, stop);
				end else begin
					queue_req(REQ_FIND, pos, $urandom_range(0, 8191));
				end
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || results_seen < requests_sent)
			@(posedge clk);
		repeat (160) @(posedge clk);
		if (expected_runs.size() != 0) begin
			$display("%0t: expected %0d more results, actual none", $time, expected_runs.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("tb_bitmap_range_run_engine: clean");
		else
			$display("tb_bitmap_range_run_engine: errors");
		$finish;
	end

	initial begin
		#7200000;
		$display("tb_bitmap_range_run_engine: errors");
		$finish;
	end

endmodule

>>> filelist.f
rtl/brr_pkg.sv
rtl/brr_ram.sv
rtl/brr_word_unit.sv
rtl/bitmap_range_run_engine.sv
tb/tb_bitmap_range_run_engine.sv
